>>> design/ilsp_pkg.sv
package ilsp_pkg;

  localparam int TIME_BITS  = 48;
  localparam int DELAY_BITS = 32;
  localparam int WAIT_BITS  = 32;
  localparam int ADDR_BITS  = 5;
  localparam int REG_BITS   = 3;

  typedef logic [TIME_BITS-1:0]  tstamp_t;
  typedef logic [DELAY_BITS-1:0] delay_t;

  localparam logic [3:0] OP_TICK      = 4'd0;
  localparam logic [3:0] OP_ACTIVITY  = 4'd1;
  localparam logic [3:0] OP_EXT_POWER = 4'd2;
  localparam logic [3:0] OP_LOCK      = 4'd3;
  localparam logic [3:0] OP_UNLOCK    = 4'd4;
  localparam logic [3:0] OP_SHUT_FAIL = 4'd5;
  localparam logic [3:0] OP_SUSP_FAIL = 4'd6;
  localparam logic [3:0] OP_CANCEL    = 4'd7;
  localparam logic [3:0] OP_UNAVAIL   = 4'd8;
  localparam logic [3:0] OP_RESTORE   = 4'd9;
  localparam logic [3:0] OP_RESUMED   = 4'd10;
  localparam logic [3:0] OP_WAKE      = 4'd11;
  localparam logic [3:0] OP_QUERY     = 4'd12;
  localparam logic [3:0] OP_INIT      = 4'd13;

  localparam logic [1:0] MODE_ACTIVE  = 2'd0;
  localparam logic [1:0] MODE_LOCKED  = 2'd1;
  localparam logic [1:0] MODE_SUSPEND = 2'd2;

  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_LOCK     = 2'd1;
  localparam logic [1:0] ACT_SUSPEND  = 2'd2;
  localparam logic [1:0] ACT_SHUTDOWN = 2'd3;

  localparam logic [REG_BITS-1:0] REG_IDLE     = 3'd0;
  localparam logic [REG_BITS-1:0] REG_SUSP     = 3'd1;
  localparam logic [REG_BITS-1:0] REG_SHUT     = 3'd2;
  localparam logic [REG_BITS-1:0] REG_SOL      = 3'd3;
  localparam logic [REG_BITS-1:0] REG_UNPLUG   = 3'd4;
  localparam logic [REG_BITS-1:0] REG_RETRY    = 3'd5;
  localparam logic [REG_BITS-1:0] REG_RESUME   = 3'd6;

  localparam delay_t RST_IDLE   = 32'd60000;
  localparam delay_t RST_SUSP   = 32'd20000;
  localparam delay_t RST_SHUT   = 32'd0;
  localparam logic   RST_SOL    = 1'b0;
  localparam delay_t RST_UNPLUG = 32'd10000;
  localparam delay_t RST_RETRY  = 32'd5000;
  localparam delay_t RST_RESUME = 32'd20000;

  localparam logic signed [WAIT_BITS-1:0] WAIT_NONE = -32'sd1;

  typedef struct packed {
    delay_t idle_timeout_ms;
    delay_t suspend_after_lock_ms;
    delay_t shutdown_after_lock_ms;
    logic   suspend_on_lock_enable;
    delay_t unplug_guard_ms;
    delay_t retry_delay_ms;
    delay_t resume_guard_ms;
  } cfg_t;

  typedef struct packed {
    logic    valid;
    tstamp_t t;
  } mark_t;

  typedef struct packed {
    logic [1:0] mode;
    tstamp_t    last_act;
    mark_t      lock;
    mark_t      unplug;
    mark_t      susp_retry;
    mark_t      shut_retry;
    logic       ext_known;
    logic       ext_online;
    logic       blocked;
    logic       wake_suppress;
  } state_t;

  localparam state_t STATE_RESET = '{
    mode: MODE_ACTIVE, last_act: '0, lock: '0, unplug: '0, susp_retry: '0,
    shut_retry: '0, ext_known: 1'b0, ext_online: 1'b0, blocked: 1'b0,
    wake_suppress: 1'b0};

  typedef struct packed {
    logic [3:0] opcode;
    tstamp_t    now_ms;
    logic       power_known;
    logic       power_online;
    logic       key_pressed;
  } req_t;

  typedef struct packed {
    logic [1:0]                   action;
    logic                         accepted;
    logic signed [WAIT_BITS-1:0]  wait_ms;
    logic [1:0]                   mode;
  } rsp_t;

endpackage

>>> design/ilsp_if.sv
interface ilsp_req_if;
  logic                 valid;
  logic                 ready;
  logic [3:0]           opcode;
  ilsp_pkg::tstamp_t    now_ms;
  logic                 power_known;
  logic                 power_online;
  logic                 key_pressed;

  modport source (output valid, opcode, now_ms, power_known, power_online, key_pressed,
                  input ready);
  modport sink (input valid, opcode, now_ms, power_known, power_online, key_pressed,
                output ready);
endinterface

interface ilsp_rsp_if;
  logic                                      valid;
  logic                                      ready;
  logic [1:0]                                action;
  logic                                      accepted;
  logic signed [ilsp_pkg::WAIT_BITS-1:0]     wait_ms;
  logic [1:0]                                mode;

  modport source (output valid, action, accepted, wait_ms, mode, input ready);
  modport sink (input valid, action, accepted, wait_ms, mode, output ready);
endinterface

>>> design/ilsp_cfg.sv
module ilsp_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ilsp_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output ilsp_pkg::cfg_t                     cfg
);

  logic [ilsp_pkg::REG_BITS-1:0] idx;
  logic                          wr;

  assign idx    = paddr[ilsp_pkg::ADDR_BITS-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_timeout_ms        <= ilsp_pkg::RST_IDLE;
      cfg.suspend_after_lock_ms  <= ilsp_pkg::RST_SUSP;
      cfg.shutdown_after_lock_ms <= ilsp_pkg::RST_SHUT;
      cfg.suspend_on_lock_enable <= ilsp_pkg::RST_SOL;
      cfg.unplug_guard_ms        <= ilsp_pkg::RST_UNPLUG;
      cfg.retry_delay_ms         <= ilsp_pkg::RST_RETRY;
      cfg.resume_guard_ms        <= ilsp_pkg::RST_RESUME;
    end else if (wr) begin
      unique case (idx)
        ilsp_pkg::REG_IDLE:   cfg.idle_timeout_ms        <= pwdata;
        ilsp_pkg::REG_SUSP:   cfg.suspend_after_lock_ms  <= pwdata;
        ilsp_pkg::REG_SHUT:   cfg.shutdown_after_lock_ms <= pwdata;
        ilsp_pkg::REG_SOL:    cfg.suspend_on_lock_enable <= pwdata[0];
        ilsp_pkg::REG_UNPLUG: cfg.unplug_guard_ms        <= pwdata;
        ilsp_pkg::REG_RETRY:  cfg.retry_delay_ms         <= pwdata;
        ilsp_pkg::REG_RESUME: cfg.resume_guard_ms        <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ilsp_pkg::REG_IDLE:   prdata = cfg.idle_timeout_ms;
      ilsp_pkg::REG_SUSP:   prdata = cfg.suspend_after_lock_ms;
      ilsp_pkg::REG_SHUT:   prdata = cfg.shutdown_after_lock_ms;
      ilsp_pkg::REG_SOL:    prdata = {31'd0, cfg.suspend_on_lock_enable};
      ilsp_pkg::REG_UNPLUG: prdata = cfg.unplug_guard_ms;
      ilsp_pkg::REG_RETRY:  prdata = cfg.retry_delay_ms;
      ilsp_pkg::REG_RESUME: prdata = cfg.resume_guard_ms;
      default:              prdata = '0;
    endcase
  end

endmodule

>>> design/ilsp_eval.sv
module ilsp_eval (
  input  ilsp_pkg::cfg_t   cfg,
  input  ilsp_pkg::state_t st,
  input  ilsp_pkg::req_t   item,
  output ilsp_pkg::state_t st_next,
  output ilsp_pkg::rsp_t   res
);

  localparam int TB = ilsp_pkg::TIME_BITS;
  localparam int WB = ilsp_pkg::WAIT_BITS - 1;

  function automatic ilsp_pkg::tstamp_t sat_add(ilsp_pkg::tstamp_t a, ilsp_pkg::delay_t d);
    logic [TB:0] s;
    s = {1'b0, a} + {{(TB + 1 - ilsp_pkg::DELAY_BITS){1'b0}}, d};
    return s[TB] ? '1 : s[TB-1:0];
  endfunction

  function automatic ilsp_pkg::tstamp_t tmax(ilsp_pkg::tstamp_t a, ilsp_pkg::tstamp_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [WB-1:0] wait_for(ilsp_pkg::tstamp_t d, ilsp_pkg::tstamp_t now);
    ilsp_pkg::tstamp_t r;
    r = d - now;
    if (d <= now) return '0;
    if (|r[TB-1:WB]) return '1;
    return r[WB-1:0];
  endfunction

  ilsp_pkg::tstamp_t now;
  logic              offline_now;
  logic              off_ok, lock_ok, sh_ok, su_ok;
  ilsp_pkg::tstamp_t guard_end, lock_d, sh_d, su_d, su_base, new_d;
  ilsp_pkg::delay_t  dsel;
  logic              raise_hit;
  logic [WB-1:0]     w_lock, w_sh, w_su, best;
  logic              found;

  assign now         = item.now_ms;
  assign offline_now = st.ext_known & ~st.ext_online;

  assign off_ok    = offline_now & st.unplug.valid;
  assign guard_end = sat_add(st.unplug.t, cfg.unplug_guard_ms);

  assign lock_ok = (st.mode == ilsp_pkg::MODE_ACTIVE) & (cfg.idle_timeout_ms != '0) & offline_now;
  assign lock_d  = sat_add(st.last_act, cfg.idle_timeout_ms);

  assign sh_ok = (cfg.shutdown_after_lock_ms != '0) & (st.mode == ilsp_pkg::MODE_LOCKED) &
                 st.lock.valid & off_ok;
  assign sh_d  = tmax(tmax(sat_add(st.lock.t, cfg.shutdown_after_lock_ms), guard_end),
                      st.shut_retry.valid ? st.shut_retry.t : '0);

  assign su_ok   = (st.mode == ilsp_pkg::MODE_LOCKED) & ~st.blocked &
                   ((cfg.suspend_after_lock_ms != '0) | cfg.suspend_on_lock_enable) &
                   (cfg.shutdown_after_lock_ms == '0) & off_ok;
  assign su_base = st.lock.valid ? sat_add(st.lock.t, cfg.suspend_after_lock_ms) : '0;
  assign su_d    = tmax(tmax(su_base, guard_end),
                        st.susp_retry.valid ? st.susp_retry.t : '0);

  always_comb begin
    unique case (item.opcode)
      ilsp_pkg::OP_EXT_POWER: dsel = cfg.idle_timeout_ms;
      ilsp_pkg::OP_RESUMED:   dsel = cfg.resume_guard_ms;
      default:                dsel = cfg.retry_delay_ms;
    endcase
  end

  assign new_d     = sat_add(now, dsel);
  assign raise_hit = ~st.susp_retry.valid | (new_d > st.susp_retry.t);

  assign w_lock = wait_for(lock_d, now);
  assign w_sh   = wait_for(sh_d, now);
  assign w_su   = wait_for(su_d, now);

  always_comb begin
    found = lock_ok;
    best  = w_lock;
    if (sh_ok && (!found || w_sh < best)) begin
      found = 1'b1;
      best  = w_sh;
    end
    if (su_ok && (!found || w_su < best)) begin
      found = 1'b1;
      best  = w_su;
    end
  end

  always_comb begin
    st_next      = st;
    res.action   = ilsp_pkg::ACT_NONE;
    res.accepted = 1'b0;
    res.wait_ms  = '0;
    unique case (item.opcode)
      ilsp_pkg::OP_TICK: begin
        priority if (sh_ok && now >= sh_d) begin
          st_next.shut_retry = '{valid: 1'b1, t: new_d};
          res.action         = ilsp_pkg::ACT_SHUTDOWN;
        end else if (lock_ok && now >= lock_d) begin
          st_next.mode             = ilsp_pkg::MODE_LOCKED;
          st_next.lock             = '{valid: 1'b1, t: now};
          st_next.susp_retry.valid = 1'b0;
          st_next.shut_retry.valid = 1'b0;
          res.action               = ilsp_pkg::ACT_LOCK;
        end else if (su_ok && now >= su_d) begin
          st_next.mode = ilsp_pkg::MODE_SUSPEND;
          res.action   = ilsp_pkg::ACT_SUSPEND;
        end
      end
      ilsp_pkg::OP_ACTIVITY: begin
        if (st.mode == ilsp_pkg::MODE_ACTIVE) st_next.last_act = now;
      end
      ilsp_pkg::OP_EXT_POWER: begin
        if (item.power_known && !item.power_online && !offline_now) begin
          st_next.unplug   = '{valid: 1'b1, t: now};
          st_next.last_act = now;
          if (st.mode != ilsp_pkg::MODE_ACTIVE) begin
            st_next.lock = '{valid: 1'b1, t: now};
            if (raise_hit) st_next.susp_retry = '{valid: 1'b1, t: new_d};
          end
        end else if (!(item.power_known && !item.power_online)) begin
          st_next.unplug.valid = 1'b0;
        end
        st_next.ext_known  = item.power_known;
        st_next.ext_online = item.power_online;
      end
      ilsp_pkg::OP_LOCK: begin
        if (st.mode == ilsp_pkg::MODE_ACTIVE) begin
          st_next.mode             = ilsp_pkg::MODE_LOCKED;
          st_next.lock             = '{valid: 1'b1, t: now};
          st_next.susp_retry.valid = 1'b0;
          st_next.shut_retry.valid = 1'b0;
          res.accepted             = 1'b1;
        end
      end
      ilsp_pkg::OP_UNLOCK: begin
        if (st.mode == ilsp_pkg::MODE_LOCKED) begin
          st_next.mode             = ilsp_pkg::MODE_ACTIVE;
          st_next.last_act         = now;
          st_next.lock.valid       = 1'b0;
          st_next.susp_retry.valid = 1'b0;
          st_next.shut_retry.valid = 1'b0;
          st_next.wake_suppress    = 1'b0;
          res.accepted             = 1'b1;
        end
      end
      ilsp_pkg::OP_SHUT_FAIL: st_next.shut_retry = '{valid: 1'b1, t: new_d};
      ilsp_pkg::OP_SUSP_FAIL: begin
        st_next.mode = ilsp_pkg::MODE_LOCKED;
        if (raise_hit) st_next.susp_retry = '{valid: 1'b1, t: new_d};
      end
      ilsp_pkg::OP_CANCEL: begin
        st_next.mode             = ilsp_pkg::MODE_LOCKED;
        st_next.susp_retry.valid = 1'b0;
      end
      ilsp_pkg::OP_UNAVAIL: begin
        st_next.mode             = ilsp_pkg::MODE_LOCKED;
        st_next.susp_retry.valid = 1'b0;
        st_next.blocked          = 1'b1;
      end
      ilsp_pkg::OP_RESTORE: begin
        st_next.mode             = ilsp_pkg::MODE_LOCKED;
        st_next.lock             = '{valid: 1'b1, t: now};
        st_next.susp_retry.valid = 1'b0;
        st_next.blocked          = 1'b1;
        st_next.wake_suppress    = 1'b1;
      end
      ilsp_pkg::OP_RESUMED: begin
        st_next.mode = ilsp_pkg::MODE_LOCKED;
        st_next.lock = '{valid: 1'b1, t: now};
        if (cfg.suspend_on_lock_enable && raise_hit)
          st_next.susp_retry = '{valid: 1'b1, t: new_d};
        st_next.blocked       = 1'b0;
        st_next.wake_suppress = 1'b1;
      end
      ilsp_pkg::OP_WAKE: begin
        if (st.wake_suppress) begin
          if (!item.key_pressed) st_next.wake_suppress = 1'b0;
          res.accepted = 1'b1;
        end
      end
      ilsp_pkg::OP_QUERY: begin
        res.wait_ms = found ? signed'({1'b0, best}) : ilsp_pkg::WAIT_NONE;
      end
      ilsp_pkg::OP_INIT: begin
        st_next          = ilsp_pkg::STATE_RESET;
        st_next.last_act = now;
      end
      default: ;
    endcase
    res.mode = st_next.mode;
  end

endmodule

>>> design/idle_lock_suspend_power_policy_core.sv
// Power-mode policy controller: active, locked and suspend-prepare modes.
// req channel: one beat per event (opcode, now_ms, power sample, wake key).
// rsp channel: one beat per event with action, accepted, wait_ms and mode.
// APB port: seven 32-bit policy registers at byte offsets 4*i; writes take
// effect at the access cycle, reads return the current value, pready is
// tied high. The user must change registers only with no event in flight; not enforced.
// A beat accepted on req is evaluated from the input register against the
// policy state, and its result loads into the result register when free.
// Throughput is one beat per cycle while rsp is not stalled; the state and
// result registers load at the same edge; the next event sees the new state.
// The longest path is the timeout query: a saturating 48+32 add, a
// three-way maximum, a subtract from now_ms and a three-way minimum.
// Reset (synchronous, active high) empties both stages, sets mode active,
// clears all stamps and flags and loads the default register values.
// A stalled rsp holds its beat; the input register then holds too, and req
// stays ready only while that input register is empty.
module idle_lock_suspend_power_policy_core (
  input  logic                               clk,
  input  logic                               rst,
  ilsp_req_if.sink                           req,
  ilsp_rsp_if.source                         rsp,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ilsp_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  ilsp_pkg::cfg_t   cfg;
  ilsp_pkg::state_t st, st_next;
  ilsp_pkg::req_t   s1_req;
  ilsp_pkg::rsp_t   res, out_rsp;
  logic             s1_valid;
  logic             out_valid;
  logic             out_free;
  logic             s1_move;

  ilsp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ilsp_eval u_eval (
    .cfg     (cfg),
    .st      (st),
    .item    (s1_req),
    .st_next (st_next),
    .res     (res)
  );

  assign out_free  = ~out_valid | rsp.ready;
  assign s1_move   = s1_valid & out_free;
  assign req.ready = ~s1_valid | out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= ilsp_pkg::STATE_RESET;
    end else begin
      if (req.ready) s1_valid <= req.valid;
      if (out_free) out_valid <= s1_valid;
      if (s1_move) st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req <= '{opcode: req.opcode, now_ms: req.now_ms, power_known: req.power_known,
                  power_online: req.power_online, key_pressed: req.key_pressed};
    end
    if (s1_move) out_rsp <= res;
  end

  assign rsp.valid    = out_valid;
  assign rsp.action   = out_rsp.action;
  assign rsp.accepted = out_rsp.accepted;
  assign rsp.wait_ms  = out_rsp.wait_ms;
  assign rsp.mode     = out_rsp.mode;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int                   CYCLE_LIMIT = 300000;
  localparam int                   DRAIN_CYCLES = 8;
  localparam int                   HOLD_CYCLES = 400;
  localparam int                   BEATS_PER_PHASE = 62;
  localparam int                   PHASES = 8;
  localparam ilsp_pkg::tstamp_t    T_MAX = '1;
  localparam logic [3:0]           OP_SPARE_A = 4'd14;
  localparam logic [3:0]           OP_SPARE_B = 4'd15;

  typedef struct {
    ilsp_pkg::req_t ev;
    bit             typed;
    ilsp_pkg::rsp_t rsp;
  } plan_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ilsp_pkg::ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  ilsp_req_if req_bus ();
  ilsp_rsp_if rsp_bus ();

  idle_lock_suspend_power_policy_core u_top (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  ilsp_pkg::state_t   st;
  ilsp_pkg::cfg_t     cfg_now;
  ilsp_pkg::rsp_t     expected_rsp[$];
  plan_row_t          plan[$];
  int                 fails = 0;
  int                 cycle_cnt = 0;
  int unsigned        tx_idle = 0;
  int unsigned        rx_idle = 0;
  bit                 hold_go = 1'b0;
  int                 hold_cnt = 0;
  ilsp_pkg::tstamp_t  clock_ms = '0;
  int unsigned        step_max = 20000;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic ilsp_pkg::tstamp_t sat_sum(ilsp_pkg::tstamp_t base,
                                                ilsp_pkg::delay_t dly);
    logic [ilsp_pkg::TIME_BITS:0] s;
    s = {1'b0, base} + {{(ilsp_pkg::TIME_BITS + 1 - ilsp_pkg::DELAY_BITS){1'b0}}, dly};
    return s[ilsp_pkg::TIME_BITS] ? T_MAX : s[ilsp_pkg::TIME_BITS-1:0];
  endfunction

  function automatic ilsp_pkg::mark_t mark(ilsp_pkg::tstamp_t t);
    ilsp_pkg::mark_t m;
    m.valid = 1'b1;
    m.t = t;
    return m;
  endfunction

  function automatic bit guard_end(output ilsp_pkg::tstamp_t g);
    g = '0;
    if (!st.ext_known || st.ext_online || !st.unplug.valid) return 1'b0;
    g = sat_sum(st.unplug.t, cfg_now.unplug_guard_ms);
    return 1'b1;
  endfunction

  function automatic bit lock_due_at(output ilsp_pkg::tstamp_t d);
    d = '0;
    if (st.mode != ilsp_pkg::MODE_ACTIVE || cfg_now.idle_timeout_ms == 0 ||
        !st.ext_known || st.ext_online) return 1'b0;
    d = sat_sum(st.last_act, cfg_now.idle_timeout_ms);
    return 1'b1;
  endfunction

  function automatic bit shut_due_at(output ilsp_pkg::tstamp_t d);
    ilsp_pkg::tstamp_t g;
    d = '0;
    if (cfg_now.shutdown_after_lock_ms == 0 || st.mode != ilsp_pkg::MODE_LOCKED ||
        !st.lock.valid || !guard_end(g)) return 1'b0;
    d = sat_sum(st.lock.t, cfg_now.shutdown_after_lock_ms);
    if (g > d) d = g;
    if (st.shut_retry.valid && st.shut_retry.t > d) d = st.shut_retry.t;
    return 1'b1;
  endfunction

  function automatic bit susp_due_at(output ilsp_pkg::tstamp_t d);
    ilsp_pkg::tstamp_t g;
    d = '0;
    if (st.mode != ilsp_pkg::MODE_LOCKED || st.blocked ||
        (cfg_now.suspend_after_lock_ms == 0 && !cfg_now.suspend_on_lock_enable) ||
        cfg_now.shutdown_after_lock_ms != 0 || !guard_end(g)) return 1'b0;
    d = st.lock.valid ? sat_sum(st.lock.t, cfg_now.suspend_after_lock_ms) : '0;
    if (g > d) d = g;
    if (st.susp_retry.valid && st.susp_retry.t > d) d = st.susp_retry.t;
    return 1'b1;
  endfunction

  function automatic void raise_susp_retry(ilsp_pkg::tstamp_t d);
    if (!st.susp_retry.valid || d > st.susp_retry.t) st.susp_retry = mark(d);
  endfunction

  function automatic longint ms_to(ilsp_pkg::tstamp_t d, ilsp_pkg::tstamp_t now);
    ilsp_pkg::tstamp_t r;
    if (d <= now) return 0;
    r = d - now;
    return (r > 48'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(r);
  endfunction

  function automatic ilsp_pkg::rsp_t policy_step(ilsp_pkg::req_t e);
    ilsp_pkg::rsp_t    o;
    ilsp_pkg::tstamp_t d;
    longint            w;
    longint            c;
    logic              off;
    o.action = ilsp_pkg::ACT_NONE;
    o.accepted = 1'b0;
    o.wait_ms = '0;
    case (e.opcode)
      ilsp_pkg::OP_TICK: begin
        if (shut_due_at(d) && e.now_ms >= d) begin
          st.shut_retry = mark(sat_sum(e.now_ms, cfg_now.retry_delay_ms));
          o.action = ilsp_pkg::ACT_SHUTDOWN;
        end else if (lock_due_at(d) && e.now_ms >= d) begin
          st.mode = ilsp_pkg::MODE_LOCKED;
          st.lock = mark(e.now_ms);
          st.susp_retry.valid = 1'b0;
          st.shut_retry.valid = 1'b0;
          o.action = ilsp_pkg::ACT_LOCK;
        end else if (susp_due_at(d) && e.now_ms >= d) begin
          st.mode = ilsp_pkg::MODE_SUSPEND;
          o.action = ilsp_pkg::ACT_SUSPEND;
        end
      end
      ilsp_pkg::OP_ACTIVITY: begin
        if (st.mode == ilsp_pkg::MODE_ACTIVE) st.last_act = e.now_ms;
      end
      ilsp_pkg::OP_EXT_POWER: begin
        off = e.power_known && !e.power_online;
        if (off && (!st.ext_known || st.ext_online)) begin
          st.unplug = mark(e.now_ms);
          st.last_act = e.now_ms;
          if (st.mode != ilsp_pkg::MODE_ACTIVE) begin
            st.lock = mark(e.now_ms);
            raise_susp_retry(sat_sum(e.now_ms, cfg_now.idle_timeout_ms));
          end
        end else if (!off) begin
          st.unplug.valid = 1'b0;
        end
        st.ext_known = e.power_known;
        st.ext_online = e.power_online;
      end
      ilsp_pkg::OP_LOCK: begin
        if (st.mode == ilsp_pkg::MODE_ACTIVE) begin
          st.mode = ilsp_pkg::MODE_LOCKED;
          st.lock = mark(e.now_ms);
          st.susp_retry.valid = 1'b0;
          st.shut_retry.valid = 1'b0;
          o.accepted = 1'b1;
        end
      end
      ilsp_pkg::OP_UNLOCK: begin
        if (st.mode == ilsp_pkg::MODE_LOCKED) begin
          st.mode = ilsp_pkg::MODE_ACTIVE;
          st.last_act = e.now_ms;
          st.lock.valid = 1'b0;
          st.susp_retry.valid = 1'b0;
          st.shut_retry.valid = 1'b0;
          st.wake_suppress = 1'b0;
          o.accepted = 1'b1;
        end
      end
      ilsp_pkg::OP_SHUT_FAIL:
        st.shut_retry = mark(sat_sum(e.now_ms, cfg_now.retry_delay_ms));
      ilsp_pkg::OP_SUSP_FAIL: begin
        st.mode = ilsp_pkg::MODE_LOCKED;
        raise_susp_retry(sat_sum(e.now_ms, cfg_now.retry_delay_ms));
      end
      ilsp_pkg::OP_CANCEL: begin
        st.mode = ilsp_pkg::MODE_LOCKED;
        st.susp_retry.valid = 1'b0;
      end
      ilsp_pkg::OP_UNAVAIL: begin
        st.mode = ilsp_pkg::MODE_LOCKED;
        st.susp_retry.valid = 1'b0;
        st.blocked = 1'b1;
      end
      ilsp_pkg::OP_RESTORE: begin
        st.mode = ilsp_pkg::MODE_LOCKED;
        st.lock = mark(e.now_ms);
        st.susp_retry.valid = 1'b0;
        st.blocked = 1'b1;
        st.wake_suppress = 1'b1;
      end
      ilsp_pkg::OP_RESUMED: begin
        st.mode = ilsp_pkg::MODE_LOCKED;
        st.lock = mark(e.now_ms);
        if (cfg_now.suspend_on_lock_enable)
          raise_susp_retry(sat_sum(e.now_ms, cfg_now.resume_guard_ms));
        st.blocked = 1'b0;
        st.wake_suppress = 1'b1;
      end
      ilsp_pkg::OP_WAKE: begin
        if (st.wake_suppress) begin
          if (!e.key_pressed) st.wake_suppress = 1'b0;
          o.accepted = 1'b1;
        end
      end
      ilsp_pkg::OP_QUERY: begin
        w = -1;
        if (lock_due_at(d)) w = ms_to(d, e.now_ms);
        if (shut_due_at(d)) begin
          c = ms_to(d, e.now_ms);
          if (w < 0 || c < w) w = c;
        end
        if (susp_due_at(d)) begin
          c = ms_to(d, e.now_ms);
          if (w < 0 || c < w) w = c;
        end
        o.wait_ms = w[31:0];
      end
      ilsp_pkg::OP_INIT: begin
        st = ilsp_pkg::STATE_RESET;
        st.last_act = e.now_ms;
      end
      default: ;
    endcase
    o.mode = st.mode;
    return o;
  endfunction

  task automatic plan_ev(input logic [3:0] op, input ilsp_pkg::tstamp_t t,
                         input logic kn, input logic on, input logic kp);
    plan_row_t row;
    row.ev.opcode = op;
    row.ev.now_ms = t;
    row.ev.power_known = kn;
    row.ev.power_online = on;
    row.ev.key_pressed = kp;
    row.typed = 1'b0;
    row.rsp = '0;
    plan.push_back(row);
  endtask

  task automatic plan_known(input logic [3:0] op, input ilsp_pkg::tstamp_t t, input logic kp,
                            input logic [1:0] act, input logic acc,
                            input logic signed [ilsp_pkg::WAIT_BITS-1:0] w,
                            input logic [1:0] md);
    plan_ev(op, t, 1'b1, 1'b1, kp);
    plan[$].typed = 1'b1;
    plan[$].rsp.action = act;
    plan[$].rsp.accepted = acc;
    plan[$].rsp.wait_ms = w;
    plan[$].rsp.mode = md;
  endtask

  task automatic send_beat(input ilsp_pkg::req_t e, input bit typed,
                           input ilsp_pkg::rsp_t want);
    ilsp_pkg::rsp_t model_rsp;
    req_bus.valid <= 1'b1;
    req_bus.opcode <= e.opcode;
    req_bus.now_ms <= e.now_ms;
    req_bus.power_known <= e.power_known;
    req_bus.power_online <= e.power_online;
    req_bus.key_pressed <= e.key_pressed;
    do @(posedge clk); while (!req_bus.ready);
    model_rsp = policy_step(e);
    expected_rsp.push_back(typed ? want : model_rsp);
  endtask

  task automatic tx_gap();
    if ($urandom_range(99) < tx_idle) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
  endtask

  task automatic settle();
    req_bus.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ilsp_pkg::REG_BITS-1:0] idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      ilsp_pkg::REG_IDLE:   cfg_now.idle_timeout_ms = v;
      ilsp_pkg::REG_SUSP:   cfg_now.suspend_after_lock_ms = v;
      ilsp_pkg::REG_SHUT:   cfg_now.shutdown_after_lock_ms = v;
      ilsp_pkg::REG_SOL:    cfg_now.suspend_on_lock_enable = v[0];
      ilsp_pkg::REG_UNPLUG: cfg_now.unplug_guard_ms = v;
      ilsp_pkg::REG_RETRY:  cfg_now.retry_delay_ms = v;
      ilsp_pkg::REG_RESUME: cfg_now.resume_guard_ms = v;
      default: ;
    endcase
  endtask

  task automatic program_phase(input int ph);
    ilsp_pkg::delay_t v_idle;
    ilsp_pkg::delay_t v_susp;
    ilsp_pkg::delay_t v_shut;
    ilsp_pkg::delay_t v_sol;
    ilsp_pkg::delay_t v_unplug;
    ilsp_pkg::delay_t v_retry;
    ilsp_pkg::delay_t v_resume;
    v_idle = $urandom_range(3000, 1);
    v_susp = $urandom_range(3000);
    v_shut = '0;
    v_sol = $urandom_range(1);
    v_unplug = $urandom_range(3000);
    v_retry = $urandom_range(3000);
    v_resume = $urandom_range(3000);
    step_max = 2000;
    case (ph)
      2: v_shut = $urandom_range(3000, 1);
      3: begin
        v_idle = '1;
        v_susp = '1;
        v_shut = '1;
        v_sol = 32'd1;
        v_unplug = '1;
        v_retry = '1;
        v_resume = '1;
        step_max = 32'hFFFF_FFFF;
      end
      4: begin
        v_idle = '0;
        v_susp = '0;
        v_sol = '0;
        v_unplug = '0;
        v_retry = '0;
        v_resume = '0;
      end
      5: begin
        v_idle = '0;
        v_susp = '0;
        v_sol = 32'd1;
        v_unplug = '0;
      end
      6: begin
        v_idle = $urandom;
        v_susp = $urandom;
        v_shut = $urandom_range(1) ? $urandom : '0;
        v_sol = $urandom;
        v_unplug = $urandom;
        v_retry = $urandom;
        v_resume = $urandom;
        step_max = 32'hFFFF_FFFF;
      end
      7: begin
        v_idle = ilsp_pkg::RST_IDLE;
        v_susp = ilsp_pkg::RST_SUSP;
        v_shut = ilsp_pkg::RST_SHUT;
        v_sol = 32'(ilsp_pkg::RST_SOL);
        v_unplug = ilsp_pkg::RST_UNPLUG;
        v_retry = ilsp_pkg::RST_RETRY;
        v_resume = ilsp_pkg::RST_RESUME;
        step_max = 30000;
      end
      default: ;
    endcase
    apb_write(ilsp_pkg::REG_IDLE, v_idle);
    apb_write(ilsp_pkg::REG_SUSP, v_susp);
    apb_write(ilsp_pkg::REG_SHUT, v_shut);
    apb_write(ilsp_pkg::REG_SOL, v_sol);
    apb_write(ilsp_pkg::REG_UNPLUG, v_unplug);
    apb_write(ilsp_pkg::REG_RETRY, v_retry);
    apb_write(ilsp_pkg::REG_RESUME, v_resume);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic ilsp_pkg::req_t random_event();
    ilsp_pkg::req_t e;
    int unsigned    r;
    r = $urandom_range(99);
    if (r < 65) clock_ms = clock_ms + ilsp_pkg::tstamp_t'($urandom_range(step_max));
    else if (r < 75)
      clock_ms = clock_ms + ilsp_pkg::tstamp_t'($urandom_range(step_max)) * 16;
    else if (r < 82) clock_ms = clock_ms - ilsp_pkg::tstamp_t'($urandom_range(step_max));
    else if (r < 88) clock_ms = T_MAX - ilsp_pkg::tstamp_t'($urandom_range(step_max));
    else if (r < 92) clock_ms = ilsp_pkg::tstamp_t'({$urandom, $urandom});
    else if (r < 94) clock_ms = ilsp_pkg::tstamp_t'($urandom_range(step_max));
    e.now_ms = clock_ms;
    r = $urandom_range(99);
    if (r < 28) e.opcode = ilsp_pkg::OP_TICK;
    else if (r < 42) e.opcode = ilsp_pkg::OP_QUERY;
    else if (r < 54) e.opcode = ilsp_pkg::OP_EXT_POWER;
    else if (r < 62) e.opcode = ilsp_pkg::OP_LOCK;
    else if (r < 67) e.opcode = ilsp_pkg::OP_UNLOCK;
    else if (r < 72) e.opcode = ilsp_pkg::OP_ACTIVITY;
    else if (r < 93)
      e.opcode = 4'($urandom_range(ilsp_pkg::OP_WAKE, ilsp_pkg::OP_SHUT_FAIL));
    else if (r < 96) e.opcode = ilsp_pkg::OP_INIT;
    else e.opcode = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
    e.power_known = ($urandom_range(9) != 0);
    e.power_online = 1'($urandom_range(1));
    e.key_pressed = 1'($urandom_range(1));
    return e;
  endfunction

  initial begin
    ilsp_pkg::rsp_t want;
    ilsp_pkg::rsp_t got;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (rsp_bus.valid && rsp_bus.ready) begin
          got.action = rsp_bus.action;
          got.accepted = rsp_bus.accepted;
          got.wait_ms = rsp_bus.wait_ms;
          got.mode = rsp_bus.mode;
          if (expected_rsp.size() == 0) begin
            $display("%0t: beat with nothing expected, actual %p", $time, got);
            fails++;
          end else begin
            want = expected_rsp.pop_front();
            if (got.action !== want.action) begin
              $display("%0t: action expected %0d actual %0d", $time, want.action, got.action);
              fails++;
            end
            if (got.accepted !== want.accepted) begin
              $display("%0t: accepted expected %0d actual %0d", $time, want.accepted,
                       got.accepted);
              fails++;
            end
            if (got.wait_ms !== want.wait_ms) begin
              $display("%0t: wait_ms expected %0d actual %0d", $time, want.wait_ms,
                       got.wait_ms);
              fails++;
            end
            if (got.mode !== want.mode) begin
              $display("%0t: mode expected %0d actual %0d", $time, want.mode, got.mode);
              fails++;
            end
          end
        end
        if (hold_cnt != 0) begin
          hold_cnt--;
          rsp_bus.ready <= 1'b0;
        end else if (hold_go) begin
          hold_go = 1'b0;
          hold_cnt = HOLD_CYCLES;
          rsp_bus.ready <= 1'b0;
        end else begin
          rsp_bus.ready <= ($urandom_range(99) >= rx_idle);
        end
      end
    end
  end

  initial begin
    int ph;
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.opcode = ilsp_pkg::OP_TICK;
    req_bus.now_ms = '0;
    req_bus.power_known = 1'b0;
    req_bus.power_online = 1'b0;
    req_bus.key_pressed = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    st = ilsp_pkg::STATE_RESET;
    cfg_now.idle_timeout_ms = ilsp_pkg::RST_IDLE;
    cfg_now.suspend_after_lock_ms = ilsp_pkg::RST_SUSP;
    cfg_now.shutdown_after_lock_ms = ilsp_pkg::RST_SHUT;
    cfg_now.suspend_on_lock_enable = ilsp_pkg::RST_SOL;
    cfg_now.unplug_guard_ms = ilsp_pkg::RST_UNPLUG;
    cfg_now.retry_delay_ms = ilsp_pkg::RST_RETRY;
    cfg_now.resume_guard_ms = ilsp_pkg::RST_RESUME;

    plan_known(ilsp_pkg::OP_QUERY, 48'd0, 1'b0, ilsp_pkg::ACT_NONE, 1'b0,
               ilsp_pkg::WAIT_NONE, ilsp_pkg::MODE_ACTIVE);
    plan_known(OP_SPARE_B, 48'd5, 1'b1, ilsp_pkg::ACT_NONE, 1'b0, '0,
               ilsp_pkg::MODE_ACTIVE);
    plan_known(ilsp_pkg::OP_LOCK, 48'd100, 1'b0, ilsp_pkg::ACT_NONE, 1'b1, '0,
               ilsp_pkg::MODE_LOCKED);
    plan_known(ilsp_pkg::OP_UNLOCK, 48'd200, 1'b0, ilsp_pkg::ACT_NONE, 1'b1, '0,
               ilsp_pkg::MODE_ACTIVE);
    plan_known(ilsp_pkg::OP_UNLOCK, 48'd300, 1'b0, ilsp_pkg::ACT_NONE, 1'b0, '0,
               ilsp_pkg::MODE_ACTIVE);
    plan_known(ilsp_pkg::OP_WAKE, 48'd300, 1'b1, ilsp_pkg::ACT_NONE, 1'b0, '0,
               ilsp_pkg::MODE_ACTIVE);
    plan_ev(ilsp_pkg::OP_EXT_POWER, 48'd1000, 1'b1, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_ACTIVITY, 48'd1500, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_QUERY, 48'd2000, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_TICK, 48'd61500, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_QUERY, 48'd61600, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_TICK, 48'd81500, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_SUSP_FAIL, 48'd81600, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_TICK, 48'd86600, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_RESUMED, 48'd90000, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_WAKE, 48'd90001, 1'b0, 1'b0, 1'b1);
    plan_ev(ilsp_pkg::OP_WAKE, 48'd90002, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_RESTORE, 48'd95000, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_TICK, 48'd200000, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_UNAVAIL, 48'd200001, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_INIT, 48'd300000, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_EXT_POWER, 48'd300000, 1'b1, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_CANCEL, 48'd300010, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_QUERY, 48'd300020, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_TICK, 48'd310000, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_SHUT_FAIL, T_MAX, 1'b0, 1'b0, 1'b0);
    plan_ev(ilsp_pkg::OP_EXT_POWER, T_MAX, 1'b0, 1'b1, 1'b1);
    plan_ev(ilsp_pkg::OP_TICK, 48'd0, 1'b0, 1'b0, 1'b0);
    plan_ev(OP_SPARE_A, T_MAX, 1'b1, 1'b1, 1'b1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      tx_gap();
      send_beat(plan[i].ev, plan[i].typed, plan[i].rsp);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph != 0) program_phase(ph);
      case (ph % 4)
        0: begin tx_idle = 0;  rx_idle = 0;  end
        1: begin tx_idle = 81; rx_idle = 0;  end
        2: begin tx_idle = 0;  rx_idle = 81; end
        default: begin tx_idle = 16; rx_idle = 16; end
      endcase
      // hold the result side off while beats keep coming
      if (ph == 0) hold_go = 1'b1;
      repeat (BEATS_PER_PHASE) begin
        tx_gap();
        send_beat(random_event(), 1'b0, '0);
      end
    end

    settle();
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/ilsp_pkg.sv
design/ilsp_if.sv
design/ilsp_cfg.sv
design/ilsp_eval.sv
design/idle_lock_suspend_power_policy_core.sv
tb/tb.sv
